[sv/eepc_pkg.sv]
`default_nettype none
package eepc_pkg;

    localparam int SLOTS   = 16;
    localparam int ADDR_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W   = $clog2(SLOTS + 1);
    localparam int IDX_W   = 4;
    localparam int ECNT_W  = 5;
    localparam int TIME_W  = 32;
    localparam int DATA_W  = 32;
    localparam int CMP_W   = CNT_W + IDX_W;

    typedef enum logic [1:0] {
        CMD_ADD     = 2'd0,
        CMD_DESTROY = 2'd1,
        CMD_SWEEP   = 2'd2,
        CMD_READ    = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_BAD_INDEX = 2'd2
    } t_status;

    typedef struct packed {
        logic              killed;
        logic [DATA_W-1:0] payload;
        logic [TIME_W-1:0] deadline;
    } t_entry;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] addr;
        t_entry            data;
    } t_mem_wr;

    typedef struct packed {
        logic              destroyed;
        logic [DATA_W-1:0] payload;
        logic [TIME_W-1:0] deadline;
        logic [ECNT_W-1:0] count;
        t_status           status;
    } t_result;

    // Count as seen on the result port: wraps to the field width.
    function automatic logic [ECNT_W-1:0] fit_count(input logic [CNT_W-1:0] cnt);
        logic [CNT_W+ECNT_W-1:0] w;
        w = {{ECNT_W{1'b0}}, cnt};
        return w[ECNT_W-1:0];
    endfunction

    function automatic logic [CMP_W-1:0] ext_idx(input logic [IDX_W-1:0] idx);
        return {{CNT_W{1'b0}}, idx};
    endfunction

    function automatic logic [CMP_W-1:0] ext_cnt(input logic [CNT_W-1:0] cnt);
        return {{IDX_W{1'b0}}, cnt};
    endfunction

endpackage
`default_nettype wire

[sv/eepc_ram.sv]
`default_nettype none
module eepc_ram (
    input  wire logic                          i_clk,
    input  wire eepc_pkg::t_mem_wr             i_wr,
    input  wire logic [eepc_pkg::ADDR_W-1:0]   i_rd_addr,
    output eepc_pkg::t_entry                   o_rd_data
);

    eepc_pkg::t_entry r_mem [eepc_pkg::SLOTS];
    eepc_pkg::t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule
`default_nettype wire

[sv/eepc_ctrl.sv]
`default_nettype none
module eepc_ctrl (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_req_valid,
    output logic                               o_req_ready,
    input  wire logic [1:0]                    i_cmd,
    input  wire logic [eepc_pkg::TIME_W-1:0]   i_deadline_ms,
    input  wire logic [eepc_pkg::DATA_W-1:0]   i_payload,
    input  wire logic [eepc_pkg::IDX_W-1:0]    i_slot_index,
    input  wire logic [eepc_pkg::TIME_W-1:0]   i_now_ms,
    output logic                               o_res_valid,
    input  wire logic                          i_res_ready,
    output eepc_pkg::t_result                  o_res,
    output eepc_pkg::t_mem_wr                  o_mem_wr,
    output logic [eepc_pkg::ADDR_W-1:0]        o_rd_addr,
    input  wire eepc_pkg::t_entry              i_rd_data
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_RMW,
        S_SWEEP,
        S_DONE
    } t_state;

    t_state                          r_state, n_state;
    logic [eepc_pkg::CNT_W-1:0]      r_count, n_count;
    logic [eepc_pkg::CNT_W-1:0]      r_pos, n_pos;
    logic [eepc_pkg::CNT_W-1:0]      r_keep, n_keep;
    eepc_pkg::t_cmd                  r_cmd, n_cmd;
    logic [eepc_pkg::TIME_W-1:0]     r_now, n_now;
    logic [eepc_pkg::ADDR_W-1:0]     r_addr, n_addr;
    eepc_pkg::t_result               r_res, n_res;

    logic                            idx_ok;
    logic [eepc_pkg::CMP_W-1:0]      idx_wide;
    logic                            survive;
    logic [eepc_pkg::CNT_W-1:0]      keep_next;

    assign idx_wide  = eepc_pkg::ext_idx(i_slot_index);
    assign idx_ok    = idx_wide < eepc_pkg::ext_cnt(r_count);
    assign survive   = !i_rd_data.killed && (r_now < i_rd_data.deadline);
    assign keep_next = r_keep + eepc_pkg::CNT_W'(survive);

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_pos     = r_pos;
        n_keep    = r_keep;
        n_cmd     = r_cmd;
        n_now     = r_now;
        n_addr    = r_addr;
        n_res     = r_res;
        o_mem_wr  = '0;
        o_rd_addr = r_pos[eepc_pkg::ADDR_W-1:0];

        unique case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    n_cmd        = eepc_pkg::t_cmd'(i_cmd);
                    n_now        = i_now_ms;
                    n_addr       = idx_wide[eepc_pkg::ADDR_W-1:0];
                    n_res        = '0;
                    n_res.status = eepc_pkg::ST_OK;
                    n_res.count  = eepc_pkg::fit_count(r_count);
                    n_state      = S_DONE;
                    unique case (eepc_pkg::t_cmd'(i_cmd))
                        eepc_pkg::CMD_ADD: begin
                            if (r_count == eepc_pkg::CNT_W'(eepc_pkg::SLOTS)) begin
                                n_res.status = eepc_pkg::ST_FULL;
                            end else begin
                                o_mem_wr.we            = 1'b1;
                                o_mem_wr.addr          = r_count[eepc_pkg::ADDR_W-1:0];
                                o_mem_wr.data.deadline = i_deadline_ms;
                                o_mem_wr.data.payload  = i_payload;
                                o_mem_wr.data.killed   = 1'b0;
                                n_count                = r_count + 1'b1;
                                n_res.count = eepc_pkg::fit_count(r_count + 1'b1);
                            end
                        end
                        eepc_pkg::CMD_DESTROY, eepc_pkg::CMD_READ: begin
                            if (idx_ok) begin
                                o_rd_addr = idx_wide[eepc_pkg::ADDR_W-1:0];
                                n_state   = S_RMW;
                            end else begin
                                n_res.status = eepc_pkg::ST_BAD_INDEX;
                            end
                        end
                        eepc_pkg::CMD_SWEEP: begin
                            if (r_count != '0) begin
                                o_rd_addr = '0;
                                n_pos     = eepc_pkg::CNT_W'(1);
                                n_keep    = '0;
                                n_state   = S_SWEEP;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_RMW: begin
                if (r_cmd == eepc_pkg::CMD_DESTROY) begin
                    o_mem_wr.we          = 1'b1;
                    o_mem_wr.addr        = r_addr;
                    o_mem_wr.data        = i_rd_data;
                    o_mem_wr.data.killed = 1'b1;
                end else begin
                    n_res.deadline  = i_rd_data.deadline;
                    n_res.payload   = i_rd_data.payload;
                    n_res.destroyed = i_rd_data.killed;
                end
                n_state = S_DONE;
            end
            S_SWEEP: begin
                // Data of entry r_pos-1 is here; the write slot never passes it.
                if (survive) begin
                    o_mem_wr.we   = 1'b1;
                    o_mem_wr.addr = r_keep[eepc_pkg::ADDR_W-1:0];
                    o_mem_wr.data = i_rd_data;
                end
                n_keep = keep_next;
                if (r_pos == r_count) begin
                    n_count     = keep_next;
                    n_res.count = eepc_pkg::fit_count(keep_next);
                    n_state     = S_DONE;
                end else begin
                    n_pos = r_pos + 1'b1;
                end
            end
            S_DONE: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_pos  <= n_pos;
        r_keep <= n_keep;
        r_cmd  <= n_cmd;
        r_now  <= n_now;
        r_addr <= n_addr;
        r_res  <= n_res;
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    assign o_req_ready = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_DONE);
    assign o_res       = r_res;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= eepc_pkg::CNT_W'(eepc_pkg::SLOTS))
        else $error("live count above pool size");

    a_keep_behind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SWEEP) |-> (r_keep < r_pos && r_pos <= r_count))
        else $error("compaction write slot overtook read position");

    a_add_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_req_valid && i_cmd == eepc_pkg::CMD_ADD &&
         r_count != eepc_pkg::CNT_W'(eepc_pkg::SLOTS))
        |=> (r_count == $past(r_count) + 1'b1))
        else $error("accepted add did not grow the pool");

    a_sweep_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SWEEP) |=> (r_count <= $past(r_count)))
        else $error("sweep grew the pool");

    a_push_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && i_res_ready) |=> (r_state == S_IDLE))
        else $error("result handed off but control not idle");

endmodule
`default_nettype wire

[sv/expiring_entry_pool_compactor.sv]
// Throughput: one request at a time; the sweep walks the entry RAM one entry per cycle
//   through its single read port, compacting survivors in place behind the read pointer.
// Reset (synchronous, active low) empties the pool; entry RAM contents are not cleared.
`default_nettype none
module expiring_entry_pool_compactor (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           s_axis_tvalid,
    output logic                s_axis_tready,
    // [31:0] deadline_ms, [63:32] payload, [67:64] slot_index, [99:68] now_ms
    input  wire logic [103:0]   s_axis_tdata,
    // [1:0] cmd
    input  wire logic [1:0]     s_axis_tuser,
    output logic                m_axis_tvalid,
    input  wire logic           m_axis_tready,
    // [1:0] status, [6:2] entry_count, [38:7] out_deadline, [70:39] out_payload,
    // [71] out_destroyed
    output logic [71:0]         m_axis_tdata
);

    logic                              res_valid;
    logic                              res_ready;
    eepc_pkg::t_result                 res;
    eepc_pkg::t_mem_wr                 mem_wr;
    logic [eepc_pkg::ADDR_W-1:0]       rd_addr;
    eepc_pkg::t_entry                  rd_data;
    logic                              r_out_valid;
    logic [71:0]                       r_out_data;

    eepc_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req_valid   (s_axis_tvalid),
        .o_req_ready   (s_axis_tready),
        .i_cmd         (s_axis_tuser),
        .i_deadline_ms (s_axis_tdata[31:0]),
        .i_payload     (s_axis_tdata[63:32]),
        .i_slot_index  (s_axis_tdata[67:64]),
        .i_now_ms      (s_axis_tdata[99:68]),
        .o_res_valid   (res_valid),
        .i_res_ready   (res_ready),
        .o_res         (res),
        .o_mem_wr      (mem_wr),
        .o_rd_addr     (rd_addr),
        .i_rd_data     (rd_data)
    );

    eepc_ram u_ram (
        .i_clk     (i_clk),
        .i_wr      (mem_wr),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // Output register: take a new result whenever the held one is gone or leaving.
    assign res_ready = !r_out_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (res_valid && res_ready) begin
            r_out_data <= {res.destroyed, res.payload, res.deadline, res.count, res.status};
        end
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res_valid;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule
`default_nettype wire
